// File: sv/turn_allocation_permission_table_core_macros.svh
// Assertion macros shared by the permission table RTL.
`ifndef TURN_ALLOCATION_PERMISSION_TABLE_CORE_MACROS_SVH
`define TURN_ALLOCATION_PERMISSION_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define TAPT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tapt: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define TAPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tapt: next-cycle check failed");
`else
`define TAPT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TAPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/tapt_pkg.sv
package tapt_pkg;

   // Table geometry
   localparam int MAX_PERMISSIONS = 16;
   localparam int IDX_W = (MAX_PERMISSIONS > 1) ? $clog2(MAX_PERMISSIONS) : 1;
   localparam int CNT_W = $clog2(MAX_PERMISSIONS + 1);
   localparam int ENTRIES_W = 5;

   // Field widths
   localparam int CMD_W = 3;
   localparam int ADDR_W = 32;
   localparam int BYTES_W = 16;
   localparam int WORD_W = 32;
   localparam int PERM_LIFE_W = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0] UNLIMITED_BANDWIDTH = 32'd99999999;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWEEP    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CHECK    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_USAGE    = 3'd6;
   localparam logic [CMD_W-1:0] CMD_LIFETIME = 3'd7;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BANDWIDTH_LIMIT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERMISSION_LIFETIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_LIFETIME    = 2'd2;

   localparam logic [WORD_W-1:0] RESET_PERMISSION_LIFETIME = 32'd300;
   localparam logic [WORD_W-1:0] RESET_INITIAL_LIFETIME    = 32'd600;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [ADDR_W-1:0]  peer_address;
      logic [BYTES_W-1:0] byte_count;
      logic [WORD_W-1:0]  new_lifetime;
   } req_payload_type;

   typedef struct packed {
      logic                 permitted;
      logic                 found;
      logic                 table_full;
      logic [WORD_W-1:0]    time_left;
      logic [WORD_W-1:0]    bandwidth_left;
      logic [WORD_W-1:0]    bytes_used;
      logic [ENTRIES_W-1:0] entries_used;
      logic                 alloc_ok;
   } rsp_payload_type;

   // Sequencer commands to the datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic apply;
      logic timing;
      logic result;
   } dp_cmd_type;

   // Datapath status back to the sequencer
   typedef struct packed {
      logic scan_last;
   } dp_status_type;

   // Commands that walk the table
   function automatic logic cmd_scans(input logic [CMD_W-1:0] cmd);
      return (cmd == CMD_ADD) || (cmd == CMD_REMOVE) || (cmd == CMD_SWEEP) ||
             (cmd == CMD_CHECK);
   endfunction

endpackage

// File: sv/tapt_datapath.sv
`include "turn_allocation_permission_table_core_macros.svh"

module tapt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tapt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tapt_pkg::WORD_W-1:0]    csr_wdata,
   input  tapt_pkg::req_payload_type      req_payload,
   input  tapt_pkg::dp_cmd_type           dp_cmd,
   output tapt_pkg::dp_status_type        dp_status,
   output tapt_pkg::rsp_payload_type      rsp_payload
);

   localparam int N = tapt_pkg::MAX_PERMISSIONS;
   localparam int IW = tapt_pkg::IDX_W;
   localparam int CW = tapt_pkg::CNT_W;
   localparam int WW = tapt_pkg::WORD_W;

   // Transaction and result registers
   tapt_pkg::req_payload_type req_ff;
   tapt_pkg::rsp_payload_type rsp_ff, rsp_in;

   // Table storage
   logic [N-1:0]                      valid_ff, valid_in;
   logic [tapt_pkg::ADDR_W-1:0]       addr_mem_ff [N];
   logic [WW-1:0]                     stamp_mem_ff [N];
   logic                              addr_we, stamp_we;
   logic [IW-1:0]                     wr_idx;

   // Allocation state and settings
   logic [CW-1:0]                     count_ff, count_in;
   logic [WW-1:0]                     now_ff, now_in;
   logic [WW-1:0]                     last_ff, last_in;
   logic [WW-1:0]                     alife_ff, alife_in;
   logic [WW-1:0]                     used_ff, used_in;
   logic [WW-1:0]                     bw_limit_ff, bw_limit_in;
   logic [tapt_pkg::PERM_LIFE_W-1:0]  perm_life_ff, perm_life_in;

   // Scan bookkeeping and result flags
   logic [IW-1:0]                     scan_idx_ff, scan_idx_in;
   logic                              hit_ff, hit_in;
   logic [IW-1:0]                     hit_idx_ff, hit_idx_in;
   logic                              free_ok_ff, free_ok_in;
   logic [IW-1:0]                     free_idx_ff, free_idx_in;
   logic                              permitted_ff, permitted_in;
   logic                              found_ff, found_in;
   logic                              full_ff, full_in;
   logic [WW-1:0]                     elapsed_ff;

   // Per-cycle arithmetic
   logic [WW-1:0]                     age;
   logic [WW:0]                       used_sum;
   logic [WW:0]                       tl_diff;
   logic [WW:0]                       bw_diff;
   logic [WW-1:0]                     time_left;
   logic [WW-1:0]                     bw_left;

   assign age = now_ff - stamp_mem_ff[scan_idx_ff];
   assign used_sum = {1'b0, used_ff} + {{(WW + 1 - tapt_pkg::BYTES_W){1'b0}},
                                        req_ff.byte_count};
   assign tl_diff = {1'b0, alife_ff} - {1'b0, elapsed_ff};
   assign bw_diff = {1'b0, bw_limit_ff} - {1'b0, used_ff};

   // Time left saturates at zero; bandwidth has an unlimited marker
   always_comb begin
      time_left = tl_diff[WW] ? '0 : tl_diff[WW-1:0];
      if (bw_limit_ff == '0) begin
         bw_left = tapt_pkg::UNLIMITED_BANDWIDTH;
      end else begin
         bw_left = bw_diff[WW] ? '0 : bw_diff[WW-1:0];
      end
   end

   // Next-state logic
   always_comb begin
      valid_in     = valid_ff;
      count_in     = count_ff;
      now_in       = now_ff;
      last_in      = last_ff;
      alife_in     = alife_ff;
      used_in      = used_ff;
      bw_limit_in  = bw_limit_ff;
      perm_life_in = perm_life_ff;
      scan_idx_in  = scan_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      permitted_in = permitted_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      addr_we      = 1'b0;
      stamp_we     = 1'b0;
      wr_idx       = hit_idx_ff;

      // Take configuration writes; unknown indexes drop
      if (csr_wr_en) begin
         case (csr_index)
            tapt_pkg::REG_BANDWIDTH_LIMIT:     bw_limit_in = csr_wdata;
            tapt_pkg::REG_PERMISSION_LIFETIME:
               perm_life_in = csr_wdata[tapt_pkg::PERM_LIFE_W-1:0];
            tapt_pkg::REG_INITIAL_LIFETIME:    alife_in = csr_wdata;
            default: ;
         endcase
      end

      // Start a transaction
      if (dp_cmd.load) begin
         scan_idx_in  = '0;
         hit_in       = 1'b0;
         free_ok_in   = 1'b0;
         permitted_in = 1'b0;
         found_in     = 1'b0;
         full_in      = 1'b0;
      end

      // Visit one entry per cycle
      if (dp_cmd.scan) begin
         if (valid_ff[scan_idx_ff] && !hit_ff &&
             (addr_mem_ff[scan_idx_ff] == req_ff.peer_address)) begin
            hit_in     = 1'b1;
            hit_idx_in = scan_idx_ff;
         end
         if (!valid_ff[scan_idx_ff] && !free_ok_ff) begin
            free_ok_in  = 1'b1;
            free_idx_in = scan_idx_ff;
         end
         if ((req_ff.cmd == tapt_pkg::CMD_SWEEP) && valid_ff[scan_idx_ff] &&
             (age >= {{(WW - tapt_pkg::PERM_LIFE_W){1'b0}}, perm_life_ff})) begin
            valid_in[scan_idx_ff] = 1'b0;
            count_in = count_ff - 1'b1;
         end
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      // Commit the command
      if (dp_cmd.apply) begin
         case (req_ff.cmd)
            tapt_pkg::CMD_TICK: now_in = now_ff + 1'b1;
            tapt_pkg::CMD_ADD: begin
               if (hit_ff) begin
                  stamp_we = 1'b1;
                  found_in = 1'b1;
               end else if (free_ok_ff) begin
                  wr_idx   = free_idx_ff;
                  stamp_we = 1'b1;
                  addr_we  = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
            tapt_pkg::CMD_REMOVE: begin
               if (hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  count_in = count_ff - 1'b1;
                  found_in = 1'b1;
               end
            end
            tapt_pkg::CMD_CLEAR: begin
               valid_in = '0;
               count_in = '0;
            end
            tapt_pkg::CMD_SWEEP: ;
            tapt_pkg::CMD_CHECK: permitted_in = hit_ff;
            tapt_pkg::CMD_USAGE: begin
               last_in = now_ff;
               used_in = used_sum[WW] ? '1 : used_sum[WW-1:0];
            end
            tapt_pkg::CMD_LIFETIME: begin
               alife_in = req_ff.new_lifetime;
               last_in  = now_ff;
            end
            default: ;
         endcase
      end
   end

   // Assemble the result
   always_comb begin
      rsp_in.permitted      = permitted_ff;
      rsp_in.found          = found_ff;
      rsp_in.table_full     = full_ff;
      rsp_in.time_left      = time_left;
      rsp_in.bandwidth_left = bw_left;
      rsp_in.bytes_used     = used_ff;
      rsp_in.entries_used   = (tapt_pkg::ENTRIES_W)'(count_ff);
      rsp_in.alloc_ok       = (time_left != '0) && (bw_left != '0);
   end

   // Control and allocation state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         now_ff       <= '0;
         last_ff      <= '0;
         alife_ff     <= tapt_pkg::RESET_INITIAL_LIFETIME;
         used_ff      <= '0;
         bw_limit_ff  <= '0;
         perm_life_ff <= tapt_pkg::RESET_PERMISSION_LIFETIME[tapt_pkg::PERM_LIFE_W-1:0];
         scan_idx_ff  <= '0;
         hit_ff       <= 1'b0;
         free_ok_ff   <= 1'b0;
         permitted_ff <= 1'b0;
         found_ff     <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         now_ff       <= now_in;
         last_ff      <= last_in;
         alife_ff     <= alife_in;
         used_ff      <= used_in;
         bw_limit_ff  <= bw_limit_in;
         perm_life_ff <= perm_life_in;
         scan_idx_ff  <= scan_idx_in;
         hit_ff       <= hit_in;
         free_ok_ff   <= free_ok_in;
         permitted_ff <= permitted_in;
         found_ff     <= found_in;
         full_ff      <= full_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (dp_cmd.load) begin
         req_ff <= req_payload;
      end
      if (dp_cmd.timing) begin
         elapsed_ff <= now_ff - last_ff;
      end
      if (dp_cmd.result) begin
         rsp_ff <= rsp_in;
      end
      if (addr_we) begin
         addr_mem_ff[wr_idx] <= req_ff.peer_address;
      end
      if (stamp_we) begin
         stamp_mem_ff[wr_idx] <= now_ff;
      end
   end

   assign dp_status.scan_last = (scan_idx_ff == IW'(N - 1));
   assign rsp_payload = rsp_ff;

   `TAPT_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(N))
   `TAPT_ASSERT_IMPLY(a_full_not_found, clock, reset, full_ff, !found_ff && !hit_ff)
   `TAPT_ASSERT_NEXT(a_clear_empties, clock, reset, dp_cmd.apply && (req_ff.cmd == tapt_pkg::CMD_CLEAR), (count_ff == '0) && (valid_ff == '0))

endmodule

// File: sv/tapt_ctrl.sv
`include "turn_allocation_permission_table_core_macros.svh"

module tapt_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [tapt_pkg::CMD_W-1:0] req_cmd,
   input  logic                       rsp_stall,
   input  tapt_pkg::dp_status_type    dp_status,
   output logic                       req_stall,
   output logic                       rsp_valid,
   output tapt_pkg::dp_cmd_type       dp_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_TIME,
      ST_RESULT,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = req_valid && !req_stall_ff;

   // Sequence the transaction
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = tapt_pkg::cmd_scans(req_cmd) ? ST_SCAN : ST_APPLY;
            end
         end
         ST_SCAN: begin
            if (dp_status.scan_last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY:  state_in = ST_TIME;
         ST_TIME:   state_in = ST_RESULT;
         ST_RESULT: begin
            state_in     = ST_HOLD;
            rsp_valid_in = 1'b1;
         end
         ST_HOLD: begin
            if (!rsp_stall) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Drive datapath commands
   always_comb begin
      dp_cmd.load   = (state_ff == ST_IDLE) && accept;
      dp_cmd.scan   = (state_ff == ST_SCAN);
      dp_cmd.apply  = (state_ff == ST_APPLY);
      dp_cmd.timing = (state_ff == ST_TIME);
      dp_cmd.result = (state_ff == ST_RESULT);
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

   `TAPT_ASSERT_NEXT(a_accept_blocks, clock, reset, accept, req_stall_ff)
   `TAPT_ASSERT_IMPLY(a_rsp_blocks_req, clock, reset, rsp_valid_ff, req_stall_ff)
   `TAPT_ASSERT_NEXT(a_scan_ends, clock, reset, (state_ff == ST_SCAN) && dp_status.scan_last, state_ff == ST_APPLY)

endmodule

// File: sv/turn_allocation_permission_table_core.sv
// Permission table for one relay allocation. Each accepted transaction (tick, add,
// remove, clear, sweep, check, usage, set lifetime) returns exactly one result
// describing the allocation after the command. Add, remove, sweep and check walk
// the 16-entry table one entry per clock, then apply, time and result; the other
// commands go straight to apply. A new transaction is taken only after the
// previous result has been taken, in the cycle after that handshake at the
// earliest. Configuration writes are accepted any time but are meant for idle
// periods; writing initial_lifetime also reloads the allocation lifetime.
module turn_allocation_permission_table_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tapt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tapt_pkg::WORD_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tapt_pkg::req_payload_type      req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tapt_pkg::rsp_payload_type      rsp_payload
);

   tapt_pkg::dp_cmd_type    dp_cmd;
   tapt_pkg::dp_status_type dp_status;

   // Sequencer
   tapt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_payload.cmd),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd)
   );

   // Table and allocation state
   tapt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .rsp_payload (rsp_payload)
   );

endmodule
